// ----- design/urm_pkg.sv -----
// ----------------------------------------------------------------------------
// urm_pkg
// Shared types and constants for the ultrasonic ranging median block.
// ----------------------------------------------------------------------------
`default_nettype none

package urm_pkg;

  // round shape
  localparam int ATTEMPTS        = 5;
  localparam int TRIG_LOW_TICKS  = 2;
  localparam int TRIG_HIGH_TICKS = 10;

  localparam int IDX_W  = (ATTEMPTS > 1) ? $clog2(ATTEMPTS) : 1;
  localparam int KEPT_W = $clog2(ATTEMPTS + 1);

  // field widths
  localparam int TICK_W  = 16;
  localparam int SCALE_W = 20;
  localparam int DIST_W  = 16;
  localparam int VCNT_W  = 3;
  localparam int CIDX_W  = 3;
  localparam int CDAT_W  = 20;

  // phase codes
  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_TRIG_LOW  = 3'd1;
  localparam logic [2:0] PH_TRIG_HIGH = 3'd2;
  localparam logic [2:0] PH_WAIT_RISE = 3'd3;
  localparam logic [2:0] PH_MEASURE   = 3'd4;
  localparam logic [2:0] PH_GAP       = 3'd5;

  // register indexes
  localparam logic [CIDX_W-1:0] REG_ECHO_TIMEOUT = 3'd0;
  localparam logic [CIDX_W-1:0] REG_SPEED_SCALE  = 3'd1;
  localparam logic [CIDX_W-1:0] REG_MIN_DIST     = 3'd2;
  localparam logic [CIDX_W-1:0] REG_MAX_DIST     = 3'd3;
  localparam logic [CIDX_W-1:0] REG_GAP_TICKS    = 3'd4;

  // register reset values
  localparam logic [TICK_W-1:0]  RST_ECHO_TIMEOUT = 16'd30000;
  localparam logic [SCALE_W-1:0] RST_SPEED_SCALE  = 20'd112394;
  localparam logic [DIST_W-1:0]  RST_MIN_DIST     = 16'd200;
  localparam logic [DIST_W-1:0]  RST_MAX_DIST     = 16'd40000;
  localparam logic [TICK_W-1:0]  RST_GAP_TICKS    = 16'd50000;

  typedef struct packed {
    logic [TICK_W-1:0]  echo_timeout_ticks;
    logic [SCALE_W-1:0] speed_scale_q16;
    logic [DIST_W-1:0]  min_distance;
    logic [DIST_W-1:0]  max_distance;
    logic [TICK_W-1:0]  gap_ticks;
  } cfg_t;

  typedef struct packed {
    logic              trigger;
    logic              busy_res;
    logic              done_res;
    logic [DIST_W-1:0] distance;
    logic [VCNT_W-1:0] hit_count;
    logic              no_valid;
  } res_t;

  typedef struct packed {
    logic              wr;
    logic [DIST_W-1:0] reading;
  } ins_t;

endpackage

`default_nettype wire

// ----- design/urm_conv.sv -----
// ----------------------------------------------------------------------------
// urm_conv
// Echo width to distance: scale, round, saturate and window check.
// ----------------------------------------------------------------------------
`default_nettype none

module urm_conv (
  input  wire logic [urm_pkg::TICK_W-1:0] width,
  input  wire urm_pkg::cfg_t              cfg,
  output logic [urm_pkg::DIST_W-1:0]      reading,
  output logic                            in_window
);
  import urm_pkg::*;

  logic [TICK_W+SCALE_W-1:0] prod;
  logic [TICK_W+SCALE_W:0]   rounded;
  logic [TICK_W+SCALE_W-16:0] scaled;

  always_comb begin
    prod    = width * cfg.speed_scale_q16;
    rounded = (TICK_W+SCALE_W+1)'(prod) + (TICK_W+SCALE_W+1)'(32768);
    scaled  = rounded[TICK_W+SCALE_W:16];
    if (scaled > (TICK_W+SCALE_W-15)'(16'hFFFF)) begin
      reading = '1;
    end else begin
      reading = scaled[DIST_W-1:0];
    end
    in_window = (reading >= cfg.min_distance) && (reading <= cfg.max_distance);
  end

endmodule

`default_nettype wire

// ----- design/urm_sort.sv -----
// ----------------------------------------------------------------------------
// urm_sort
// Sorted reading list with parallel compare-insert and median read.
// ----------------------------------------------------------------------------
`default_nettype none

module urm_sort (
  input  wire logic                       clk,
  input  wire urm_pkg::ins_t              ins,
  input  wire logic [urm_pkg::KEPT_W-1:0] kept,
  input  wire logic [urm_pkg::IDX_W-1:0]  mid,
  output logic [urm_pkg::DIST_W-1:0]      mid_dist
);
  import urm_pkg::*;

  logic [DIST_W-1:0] readings      [ATTEMPTS];
  logic [DIST_W-1:0] readings_next [ATTEMPTS];
  logic [ATTEMPTS-1:0] le;

  always_comb begin
    for (int i = 0; i < ATTEMPTS; i++) begin
      le[i] = (KEPT_W'(i) < kept) && (readings[i] <= ins.reading);
    end
    if (le[0]) begin
      readings_next[0] = readings[0];
    end else begin
      readings_next[0] = ins.reading;
    end
    for (int i = 1; i < ATTEMPTS; i++) begin
      if (le[i]) begin
        readings_next[i] = readings[i];
      end else if (le[i-1]) begin
        readings_next[i] = ins.reading;
      end else begin
        readings_next[i] = readings[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ins.wr) begin
      for (int i = 0; i < ATTEMPTS; i++) begin
        readings[i] <= readings_next[i];
      end
    end
  end

  assign mid_dist = readings[mid];

endmodule

`default_nettype wire

// ----- design/urm_ctrl.sv -----
// ----------------------------------------------------------------------------
// urm_ctrl
// Ranging sequencer: trigger pulse, echo timing, gap and round result.
// ----------------------------------------------------------------------------
`default_nettype none

module urm_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          step,
  input  wire logic          start_req,
  input  wire logic          echo,
  input  wire urm_pkg::cfg_t cfg,
  output urm_pkg::res_t      res
);
  import urm_pkg::*;

  logic [2:0]          phase, phase_next, phase_cur;
  logic [TICK_W-1:0]   tick_count, tick_count_next, tick_cur;
  logic [IDX_W-1:0]    attempt_index, attempt_index_next, attempt_cur;
  logic [KEPT_W-1:0]   kept_count, kept_count_next;
  logic [TICK_W:0]     tick_inc;
  logic                start_now;
  logic                keep;
  logic [DIST_W-1:0]   reading;
  logic                in_window;
  logic [IDX_W-1:0]    mid;
  logic [KEPT_W-1:0]   half;
  logic [DIST_W-1:0]   mid_dist;
  ins_t                ins;

  urm_conv u_conv (
    .width     (tick_count),
    .cfg       (cfg),
    .reading   (reading),
    .in_window (in_window)
  );

  urm_sort u_sort (
    .clk      (clk),
    .ins      (ins),
    .kept     (kept_count),
    .mid      (mid),
    .mid_dist (mid_dist)
  );

  always_comb begin
    half = kept_count >> 1;
    if (half >= KEPT_W'(ATTEMPTS)) begin
      mid = IDX_W'(ATTEMPTS - 1);
    end else begin
      mid = half[IDX_W-1:0];
    end
  end

  always_comb begin
    start_now   = (phase == PH_IDLE) && start_req;
    phase_cur   = start_now ? PH_TRIG_LOW : phase;
    tick_cur    = start_now ? '0 : tick_count;
    attempt_cur = start_now ? '0 : attempt_index;

    tick_inc           = {1'b0, tick_cur} + (TICK_W+1)'(1);
    phase_next         = phase_cur;
    tick_count_next    = tick_cur;
    attempt_index_next = attempt_cur;
    kept_count_next    = start_now ? '0 : kept_count;
    keep               = 1'b0;

    res             = '0;
    res.busy_res    = (phase_cur != PH_IDLE);

    unique case (phase_cur)
      PH_IDLE: begin
      end
      PH_TRIG_LOW: begin
        if (tick_inc >= (TICK_W+1)'(TRIG_LOW_TICKS)) begin
          phase_next      = PH_TRIG_HIGH;
          tick_count_next = '0;
        end else begin
          tick_count_next = tick_inc[TICK_W-1:0];
        end
      end
      PH_TRIG_HIGH: begin
        res.trigger = 1'b1;
        if (tick_inc >= (TICK_W+1)'(TRIG_HIGH_TICKS)) begin
          phase_next      = PH_WAIT_RISE;
          tick_count_next = '0;
        end else begin
          tick_count_next = tick_inc[TICK_W-1:0];
        end
      end
      PH_WAIT_RISE: begin
        if (echo) begin
          phase_next      = PH_MEASURE;
          tick_count_next = TICK_W'(1);
        end else if (tick_cur >= cfg.echo_timeout_ticks) begin
          phase_next      = PH_GAP;
          tick_count_next = '0;
        end else begin
          tick_count_next = tick_inc[TICK_W-1:0];
        end
      end
      PH_MEASURE: begin
        if (!echo) begin
          keep            = in_window && (kept_count < KEPT_W'(ATTEMPTS));
          phase_next      = PH_GAP;
          tick_count_next = '0;
        end else if (tick_cur >= cfg.echo_timeout_ticks) begin
          phase_next      = PH_GAP;
          tick_count_next = '0;
        end else begin
          tick_count_next = tick_inc[TICK_W-1:0];
        end
      end
      PH_GAP: begin
        if (tick_inc >= {1'b0, cfg.gap_ticks}) begin
          tick_count_next = '0;
          if ({1'b0, attempt_cur} + (IDX_W+1)'(1) >= (IDX_W+1)'(ATTEMPTS)) begin
            res.done_res = 1'b1;
            if (kept_count > KEPT_W'(7)) begin
              res.hit_count = VCNT_W'(7);
            end else begin
              res.hit_count = VCNT_W'(kept_count);
            end
            if (kept_count == '0) begin
              res.no_valid = 1'b1;
            end else begin
              res.distance = mid_dist;
            end
            phase_next         = PH_IDLE;
            attempt_index_next = '0;
          end else begin
            attempt_index_next = attempt_cur + IDX_W'(1);
            phase_next         = PH_TRIG_LOW;
          end
        end else begin
          tick_count_next = tick_inc[TICK_W-1:0];
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase

    if (keep) begin
      kept_count_next = kept_count + KEPT_W'(1);
    end

    ins.wr      = step && keep;
    ins.reading = reading;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      tick_count    <= '0;
      attempt_index <= '0;
      kept_count    <= '0;
    end else if (step) begin
      phase         <= phase_next;
      tick_count    <= tick_count_next;
      attempt_index <= attempt_index_next;
      kept_count    <= kept_count_next;
    end
  end

endmodule

`default_nettype wire

// ----- design/ultrasonic_ranging_median_top.sv -----
// ----------------------------------------------------------------------------
// ultrasonic_ranging_median_top
// Ultrasonic echo ranging with median-of-attempts filtering.
//
// Each input transfer is one 1 us tick carrying start_req and the sampled
// echo level; every tick yields exactly one output transfer with the
// trigger level, busy/done flags and, on the done tick, the median distance
// in hundredths of a cm, the kept reading count and no_valid.
// An input transfer lands in an input register; when the output register can
// take a result, the sequencer, the scale multiply and the five-entry sorted
// insert work combinationally from it and load the output register, where the
// result is offered. One tick is taken every cycle while the output side keeps
// up.
// When out_stall is high the output register holds and the input register
// fills, then in_stall rises; nothing is dropped.
// Register writes on the cfg port are taken every cycle (cfg_ready is
// always high) and apply to the next processed tick.
// Synchronous reset empties both registers, returns the sequencer to idle
// and loads the register reset values; there is no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module ultrasonic_ranging_median_top (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic                       start_req,
  input  wire logic                       echo,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic                            trigger,
  output logic                            busy_res,
  output logic                            done_res,
  output logic [urm_pkg::DIST_W-1:0]      distance,
  output logic [urm_pkg::VCNT_W-1:0]      hit_count,
  output logic                            no_valid,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [urm_pkg::CIDX_W-1:0] cfg_index,
  input  wire logic [urm_pkg::CDAT_W-1:0] cfg_data
);
  import urm_pkg::*;

  cfg_t cfg;
  res_t res;
  res_t res_q;
  logic in_full;
  logic in_start;
  logic in_echo;
  logic step;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.echo_timeout_ticks <= RST_ECHO_TIMEOUT;
      cfg.speed_scale_q16    <= RST_SPEED_SCALE;
      cfg.min_distance       <= RST_MIN_DIST;
      cfg.max_distance       <= RST_MAX_DIST;
      cfg.gap_ticks          <= RST_GAP_TICKS;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ECHO_TIMEOUT: cfg.echo_timeout_ticks <= cfg_data[TICK_W-1:0];
        REG_SPEED_SCALE:  cfg.speed_scale_q16    <= cfg_data[SCALE_W-1:0];
        REG_MIN_DIST:     cfg.min_distance       <= cfg_data[DIST_W-1:0];
        REG_MAX_DIST:     cfg.max_distance       <= cfg_data[DIST_W-1:0];
        REG_GAP_TICKS:    cfg.gap_ticks          <= cfg_data[TICK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // input register
  assign step     = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else begin
      in_full <= (in_valid && !in_stall) || (in_full && !step);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_start <= start_req;
      in_echo  <= echo;
    end
  end

  urm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .start_req (in_start),
    .echo      (in_echo),
    .cfg       (cfg),
    .res       (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign trigger   = res_q.trigger;
  assign busy_res  = res_q.busy_res;
  assign done_res  = res_q.done_res;
  assign distance  = res_q.distance;
  assign hit_count = res_q.hit_count;
  assign no_valid  = res_q.no_valid;

  // checks
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> busy_res && !trigger)
    else $error("done without busy");

  a_no_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && no_valid |-> done_res && hit_count == '0 && distance == '0)
    else $error("no_valid with data");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !done_res |-> hit_count == '0 && distance == '0)
    else $error("result fields outside done tick");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    in_full && out_valid && out_stall |=> in_full && out_valid)
    else $error("item lost under stall");

endmodule

`default_nettype wire

// ----- bench/ultrasonic_ranging_median_top_tb.sv -----
// ----------------------------------------------------------------------------
// ultrasonic_ranging_median_top_tb
// Drives one tick per input transfer into the ranging block and checks
// every output transfer against a cycle-level prediction of the sequencer,
// the width-to-distance scaling, the in-window sorted insert and the median
// pick. Echo pulses are shaped to follow the predicted attempt timing, with
// directed rounds for timeouts, windows and rounding, and randomized rounds
// under sender/receiver idling and a long output hold.
// ----------------------------------------------------------------------------
`default_nettype none

module ultrasonic_ranging_median_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import urm_pkg::*;

  class range_scoreboard;
    logic [TICK_W-1:0]  timeout_ticks;
    logic [SCALE_W-1:0] scale;
    logic [DIST_W-1:0]  min_dist;
    logic [DIST_W-1:0]  max_dist;
    logic [TICK_W-1:0]  gap_len;
    logic [2:0]         phase;
    int unsigned        ticks;
    int unsigned        attempt;
    int unsigned        kept;
    logic [DIST_W-1:0]  readings [ATTEMPTS];
    res_t               pending [$];
    int                 errors;
    int                 rounds;

    function new();
      timeout_ticks = RST_ECHO_TIMEOUT;
      scale         = RST_SPEED_SCALE;
      min_dist      = RST_MIN_DIST;
      max_dist      = RST_MAX_DIST;
      gap_len       = RST_GAP_TICKS;
      phase         = PH_IDLE;
      ticks         = 0;
      attempt       = 0;
      kept          = 0;
      errors        = 0;
      rounds        = 0;
      foreach (readings[i]) readings[i] = '0;
    endfunction

    function void set_register(logic [CIDX_W-1:0] idx, logic [CDAT_W-1:0] data);
      case (idx)
        REG_ECHO_TIMEOUT: timeout_ticks = data[TICK_W-1:0];
        REG_SPEED_SCALE:  scale = data[SCALE_W-1:0];
        REG_MIN_DIST:     min_dist = data[DIST_W-1:0];
        REG_MAX_DIST:     max_dist = data[DIST_W-1:0];
        REG_GAP_TICKS:    gap_len = data[TICK_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_tick(bit start, bit echo_lvl);
      res_t              r;
      longint unsigned   prod;
      int unsigned       d;
      int unsigned       pos;
      int unsigned       i;
      int unsigned       mid;
      r = '0;
      if (phase == PH_IDLE && start) begin
        phase   = PH_TRIG_LOW;
        ticks   = 0;
        attempt = 0;
        kept    = 0;
      end
      if (phase != PH_IDLE) r.busy_res = 1'b1;
      case (phase)
        PH_IDLE: ;
        PH_TRIG_LOW: begin
          ticks++;
          if (ticks >= TRIG_LOW_TICKS) begin
            phase = PH_TRIG_HIGH;
            ticks = 0;
          end
        end
        PH_TRIG_HIGH: begin
          r.trigger = 1'b1;
          ticks++;
          if (ticks >= TRIG_HIGH_TICKS) begin
            phase = PH_WAIT_RISE;
            ticks = 0;
          end
        end
        PH_WAIT_RISE: begin
          if (echo_lvl) begin
            phase = PH_MEASURE;
            ticks = 1;
          end else if (ticks >= timeout_ticks) begin
            phase = PH_GAP;
            ticks = 0;
          end else begin
            ticks++;
          end
        end
        PH_MEASURE: begin
          if (!echo_lvl) begin
            // round to nearest, ties up, then saturate
            prod = 64'(ticks);
            prod = (prod * scale + 64'd32768) >> 16;
            d = (prod > 64'd65535) ? 65535 : int'(prod);
            if (d >= min_dist && d <= max_dist && kept < ATTEMPTS) begin
              pos = 0;
              while (pos < kept && readings[pos] <= d) pos++;
              for (i = kept; i > pos; i--) readings[i] = readings[i-1];
              readings[pos] = d[DIST_W-1:0];
              kept++;
            end
            phase = PH_GAP;
            ticks = 0;
          end else if (ticks >= timeout_ticks) begin
            phase = PH_GAP;
            ticks = 0;
          end else begin
            ticks++;
          end
        end
        PH_GAP: begin
          ticks++;
          if (ticks >= gap_len) begin
            ticks = 0;
            if (attempt + 1 >= ATTEMPTS) begin
              r.done_res  = 1'b1;
              r.hit_count = (kept > 7) ? 3'd7 : kept[VCNT_W-1:0];
              if (kept == 0) begin
                r.no_valid = 1'b1;
              end else begin
                mid = kept / 2;
                if (mid >= ATTEMPTS) mid = ATTEMPTS - 1;
                r.distance = readings[mid];
              end
              phase   = PH_IDLE;
              attempt = 0;
              rounds++;
            end else begin
              attempt++;
              phase = PH_TRIG_LOW;
            end
          end
        end
        default: phase = PH_IDLE;
      endcase
      pending.push_back(r);
    endfunction

    function void check_field(string name, int unsigned want, int unsigned seen);
      if (want != seen) begin
        $error("%s: expected %0d, got %0d", name, want, seen);
        errors++;
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (pending.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
        return;
      end
      want = pending.pop_front();
      check_field("trigger", want.trigger, got.trigger);
      check_field("busy_res", want.busy_res, got.busy_res);
      check_field("done_res", want.done_res, got.done_res);
      check_field("distance", want.distance, got.distance);
      check_field("hit_count", want.hit_count, got.hit_count);
      check_field("no_valid", want.no_valid, got.no_valid);
    endfunction
  endclass

  logic                clk;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                start_req = 1'b0;
  logic                echo = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                trigger;
  logic                busy_res;
  logic                done_res;
  logic [DIST_W-1:0]   distance;
  logic [VCNT_W-1:0]   hit_count;
  logic                no_valid;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CIDX_W-1:0]   cfg_index = '0;
  logic [CDAT_W-1:0]   cfg_data = '0;

  range_scoreboard sb;
  int  tx_idle_pct = 11;
  int  rx_idle_pct = 54;
  int  noise_pct = 0;
  bit  hold_req = 1'b0;
  bit  armed = 1'b0;
  int  rise_left = 0;
  int  width_left = 0;
  int  rise_plan_q [$];
  int  width_plan_q [$];

  ultrasonic_ranging_median_top dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // output side: random stall, or one long hold on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (80) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(res_t'({trigger, busy_res, done_res, distance, hit_count,
                              no_valid}));
  end

  function automatic void add_plan(int rise, int width);
    rise_plan_q.push_back(rise);
    width_plan_q.push_back(width);
  endfunction

  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CDAT_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(idx, data);
    cfg_valid <= 1'b0;
  endtask

  // upper data bits beyond a 16-bit register are random and must be dropped
  task automatic load_config(int to, int sc, int mn, int mx, int gp);
    while (sb.pending.size() != 0) @(posedge clk);
    write_reg(REG_ECHO_TIMEOUT, {4'($urandom_range(15)), 16'(to)});
    write_reg(REG_SPEED_SCALE, 20'(sc));
    write_reg(REG_MIN_DIST, {4'($urandom_range(15)), 16'(mn)});
    write_reg(REG_MAX_DIST, {4'($urandom_range(15)), 16'(mx)});
    write_reg(REG_GAP_TICKS, {4'($urandom_range(15)), 16'(gp)});
  endtask

  task automatic random_config();
    int mn;
    int mx;
    mn = $urandom_range(0, 120);
    if ($urandom_range(7) == 0) mx = $urandom_range(0, mn);
    else mx = mn + $urandom_range(0, 200);
    load_config($urandom_range(0, 15), $urandom_range(0, 20'hFFFFF), mn, mx,
                $urandom_range(0, 4));
  endtask

  // echo follows the predicted attempt phase; a queued plan wins over a random one
  task automatic send_ticks(int count, int rounds);
    int k;
    int goal;
    int cap;
    bit s;
    bit e;
    k = 0;
    goal = sb.rounds + rounds;
    while (k < count || sb.rounds < goal) begin
      if ($urandom_range(99) < tx_idle_pct) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      if (sb.phase == PH_IDLE) s = ($urandom_range(3) != 0);
      else s = ($urandom_range(9) == 0);
      e = 1'($urandom_range(1));
      if (sb.phase == PH_WAIT_RISE || sb.phase == PH_MEASURE) begin
        if (!armed) begin
          armed = 1'b1;
          if (rise_plan_q.size() != 0) begin
            rise_left  = rise_plan_q.pop_front();
            width_left = width_plan_q.pop_front();
          end else begin
            cap = int'(sb.timeout_ticks) + 1;
            if (cap > 12) cap = 12;
            case ($urandom_range(9))
              0: begin
                rise_left  = int'(sb.timeout_ticks) + 1 + $urandom_range(1);
                width_left = 1;
              end
              1: begin
                rise_left  = $urandom_range(2);
                width_left = int'(sb.timeout_ticks) + $urandom_range(2);
              end
              default: begin
                rise_left  = $urandom_range(3);
                width_left = $urandom_range(1, cap);
              end
            endcase
          end
        end
        if ($urandom_range(99) >= noise_pct) begin
          if (rise_left > 0) begin
            e = 1'b0;
            rise_left--;
          end else if (width_left > 0) begin
            e = 1'b1;
            width_left--;
          end else begin
            e = 1'b0;
          end
        end
      end else begin
        armed = 1'b0;
      end
      in_valid  <= 1'b1;
      start_req <= s;
      echo      <= e;
      do @(posedge clk); while (in_stall);
      sb.note_tick(s, e);
      k++;
    end
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // indexes past the last register are ignored
    write_reg(3'd5, 20'hFFFFF);
    write_reg(3'd6, 20'h00001);
    write_reg(3'd7, 20'h5A5A5);

    // zero timeout, full scale, zero gap
    load_config(0, 20'hFFFFF, 0, 16'hFFFF, 0);
    add_plan(0, 1); add_plan(0, 2); add_plan(1, 1); add_plan(0, 0); add_plan(0, 1);
    send_ticks(4, 1);

    // zero scale into a single-point window
    load_config(1, 0, 0, 0, 1);
    add_plan(1, 1); add_plan(0, 1); add_plan(2, 1); add_plan(0, 2); add_plan(0, 1);
    send_ticks(3, 1);

    // inverted window keeps nothing
    load_config(4, 20'h10000, 100, 50, 0);
    add_plan(0, 3); add_plan(2, 4); add_plan(0, 1); add_plan(1, 5); add_plan(0, 2);
    send_ticks(3, 1);

    // half-step scale, tie rounding, inclusive window edges, even count picks upper middle
    load_config(8, 98304, 5, 11, 0);
    add_plan(0, 7); add_plan(1, 3); add_plan(0, 5); add_plan(0, 4); add_plan(0, 8);
    send_ticks(3, 1);

    tx_idle_pct = 54;
    rx_idle_pct = 11;
    noise_pct   = 10;
    random_config();
    send_ticks(60, 1);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_config();
    hold_req = 1'b1;
    send_ticks(60, 1);

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
